@@ rtl/ncc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ncc_pkg;

   // Sizing
   localparam int NUM_CLASSES   = 6;
   localparam int NUM_READINGS  = 5;
   localparam int NUM_LOCATIONS = 3;
   localparam int READING_BITS  = 10;

   localparam int LOC_BITS    = 2;
   localparam int CLASS_BITS  = $clog2(NUM_CLASSES + 1);
   localparam int SQ_BITS     = 2 * READING_BITS;
   localparam int DIST_BITS   = SQ_BITS + $clog2(NUM_READINGS);
   localparam int NUM_PAIRS   = (NUM_CLASSES + 1) / 2;

   // Class code for an unknown location
   localparam logic [CLASS_BITS-1:0] CLASS_NONE = CLASS_BITS'(NUM_CLASSES);

   // Reading order within a vector
   localparam int RD_OFF   = 0;
   localparam int RD_RED   = 1;
   localparam int RD_GREEN = 2;
   localparam int RD_BLUE  = 3;
   localparam int RD_WHITE = 4;

   typedef logic [READING_BITS-1:0] reading_type;
   typedef logic [SQ_BITS-1:0]      square_type;
   typedef logic [DIST_BITS-1:0]    dist_type;
   typedef logic [CLASS_BITS-1:0]   class_type;
   typedef logic [LOC_BITS-1:0]     loc_type;

   // Calibrated centroids per location, class order:
   // red, blue, green, white, black, yellow
   localparam reading_type REF_TABLE [NUM_LOCATIONS][NUM_CLASSES][NUM_READINGS] = '{
      '{
         '{10'd1023, 10'd440, 10'd851, 10'd977, 10'd408},
         '{10'd1023, 10'd716, 10'd636, 10'd862, 10'd480},
         '{10'd1023, 10'd731, 10'd602, 10'd933, 10'd481},
         '{10'd1007, 10'd227, 10'd315, 10'd655, 10'd156},
         '{10'd1022, 10'd902, 10'd881, 10'd985, 10'd774},
         '{10'd1019, 10'd227, 10'd368, 10'd899, 10'd175}
      },
      '{
         '{10'd1022, 10'd639, 10'd826, 10'd969, 10'd558},
         '{10'd1022, 10'd913, 10'd653, 10'd868, 10'd579},
         '{10'd1022, 10'd901, 10'd571, 10'd937, 10'd524},
         '{10'd1010, 10'd389, 10'd290, 10'd661, 10'd207},
         '{10'd1022, 10'd967, 10'd863, 10'd976, 10'd801},
         '{10'd1020, 10'd444, 10'd380, 10'd906, 10'd273}
      },
      '{
         '{10'd1023, 10'd654, 10'd965, 10'd932, 10'd597},
         '{10'd1023, 10'd875, 10'd873, 10'd659, 10'd561},
         '{10'd1022, 10'd930, 10'd866, 10'd855, 10'd702},
         '{10'd1022, 10'd404, 10'd580, 10'd404, 10'd240},
         '{10'd1022, 10'd912, 10'd944, 10'd885, 10'd758},
         '{10'd1016, 10'd412, 10'd652, 10'd761, 10'd329}
      }
   };

endpackage

`default_nettype wire

@@ rtl/nearest_centroid_color_classifier.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Nearest-centroid ball color classifier.
// req_ channel: one item per handshake (valid high, stall low) carries a
// sensor location and five photo readings (LED off, red, green, blue, white).
// rsp_ channel: one item per request, in order: the nearest class (0 red,
// 1 blue, 2 green, 3 white, 4 black, 5 yellow, 6 none) and its squared
// distance. An unknown location gives class none and distance 0.
// Pipeline of five register stages: difference, square, sum, pairwise
// minimum, final minimum. One item is accepted per cycle while the output
// is taken.
// Each stage holds while the next one is full and stalled, so an output
// stall fills the empty stages first and then raises req_stall; no item is
// lost or repeated. Synchronous reset empties all stages; payload registers
// are not reset.

module nearest_centroid_color_classifier (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire ncc_pkg::loc_type       req_location_sel,
   input  wire ncc_pkg::reading_type   req_reading_off,
   input  wire ncc_pkg::reading_type   req_reading_red,
   input  wire ncc_pkg::reading_type   req_reading_green,
   input  wire ncc_pkg::reading_type   req_reading_blue,
   input  wire ncc_pkg::reading_type   req_reading_white,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output ncc_pkg::class_type          rsp_ball_class,
   output ncc_pkg::dist_type           rsp_best_distance_sq
);
   import ncc_pkg::*;

   // Stage valids
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // Unknown location flag per stage
   logic bad1_ff, bad2_ff, bad3_ff, bad4_ff;
   logic bad1_in;

   // Stage payloads
   reading_type diff1_ff [NUM_CLASSES][NUM_READINGS];
   reading_type diff1_in [NUM_CLASSES][NUM_READINGS];
   square_type  sq2_ff   [NUM_CLASSES][NUM_READINGS];
   dist_type    sum3_ff  [NUM_CLASSES];
   dist_type    sum3_in  [NUM_CLASSES];
   dist_type    pdist4_ff [NUM_PAIRS];
   dist_type    pdist4_in [NUM_PAIRS];
   class_type   pidx4_ff  [NUM_PAIRS];
   class_type   pidx4_in  [NUM_PAIRS];
   class_type   class5_ff, class5_in;
   dist_type    dist5_ff,  dist5_in;

   reading_type rd [NUM_READINGS];
   reading_type sel_ref [NUM_CLASSES][NUM_READINGS];

   // Per-stage ready: a stage loads when empty or when its item moves on
   assign rdy5 = !v5_ff || !rsp_stall;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   // Gather readings and pick the centroid set for the location
   always_comb begin
      rd[RD_OFF]   = req_reading_off;
      rd[RD_RED]   = req_reading_red;
      rd[RD_GREEN] = req_reading_green;
      rd[RD_BLUE]  = req_reading_blue;
      rd[RD_WHITE] = req_reading_white;
      sel_ref = REF_TABLE[0];
      for (int l = 0; l < NUM_LOCATIONS; l++) begin
         if (32'(req_location_sel) == 32'(l)) begin
            sel_ref = REF_TABLE[l];
         end
      end
      bad1_in = 32'(req_location_sel) >= 32'(NUM_LOCATIONS);
   end

   // Stage 1: absolute differences
   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         for (int r = 0; r < NUM_READINGS; r++) begin
            diff1_in[c][r] = (rd[r] >= sel_ref[c][r]) ? rd[r] - sel_ref[c][r]
                                                       : sel_ref[c][r] - rd[r];
         end
      end
   end

   // Stage 3 input: sum of squares per class
   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         sum3_in[c] = '0;
         for (int r = 0; r < NUM_READINGS; r++) begin
            sum3_in[c] = sum3_in[c] + DIST_BITS'(sq2_ff[c][r]);
         end
      end
   end

   // Stage 4 input: pairwise minimum, earlier class wins ties
   always_comb begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
         pdist4_in[p] = sum3_ff[2*p];
         pidx4_in[p]  = CLASS_BITS'(2*p);
         if (2*p + 1 < NUM_CLASSES) begin
            if (sum3_ff[2*p+1] < sum3_ff[2*p]) begin
               pdist4_in[p] = sum3_ff[2*p+1];
               pidx4_in[p]  = CLASS_BITS'(2*p + 1);
            end
         end
      end
   end

   // Stage 5 input: minimum over pair winners, in class order; an unknown location gives class none
   always_comb begin
      class5_in = pidx4_ff[0];
      dist5_in  = pdist4_ff[0];
      for (int p = 1; p < NUM_PAIRS; p++) begin
         if (pdist4_ff[p] < dist5_in) begin
            dist5_in  = pdist4_ff[p];
            class5_in = pidx4_ff[p];
         end
      end
      if (bad4_ff) begin
         class5_in = CLASS_NONE;
         dist5_in  = '0;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (rdy1) begin
         diff1_ff <= diff1_in;
         bad1_ff  <= bad1_in;
      end
      if (rdy2) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            for (int r = 0; r < NUM_READINGS; r++) begin
               sq2_ff[c][r] <= SQ_BITS'(diff1_ff[c][r]) * SQ_BITS'(diff1_ff[c][r]);
            end
         end
         bad2_ff <= bad1_ff;
      end
      if (rdy3) begin
         sum3_ff <= sum3_in;
         bad3_ff <= bad2_ff;
      end
      if (rdy4) begin
         pdist4_ff <= pdist4_in;
         pidx4_ff  <= pidx4_in;
         bad4_ff   <= bad3_ff;
      end
      if (rdy5) begin
         class5_ff <= class5_in;
         dist5_ff  <= dist5_in;
      end
   end

   assign rsp_valid            = v5_ff;
   assign rsp_ball_class       = class5_ff;
   assign rsp_best_distance_sq = dist5_ff;

   // An empty first stage never pushes back on the requester
   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> !req_stall)
      else $error("req_stall raised with empty first stage");

   // An accepted request occupies the first stage next cycle
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted item not captured");

   // The none class always carries a zero distance
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ball_class == CLASS_NONE) |-> rsp_best_distance_sq == '0)
      else $error("none class with nonzero distance");

   // Class code never exceeds the none code
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ball_class <= CLASS_NONE)
      else $error("class code out of range");

   // A full last stage under stall leaves a full stage 4 holding
   a_hold_chain: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && rsp_stall && v4_ff) |-> !rdy4)
      else $error("stage 4 advanced into a stalled stage 5");

endmodule

`default_nettype wire

@@ tb/nearest_centroid_color_classifier_tb.sv @@
`timescale 1ns / 1ps

module nearest_centroid_color_classifier_tb;
   import ncc_pkg::*;

   localparam int CYCLE_LIMIT = 60000;
   localparam int RANDOM_ITEMS = 500;
   localparam int DRAIN_CYCLES = 12;

   typedef enum logic [CLASS_BITS-1:0] {
      CLS_RED, CLS_BLUE, CLS_GREEN, CLS_WHITE, CLS_BLACK, CLS_YELLOW, CLS_NONE
   } ball_color_type;

   typedef logic [NUM_READINGS-1:0][READING_BITS-1:0] reading_vec_type;

   typedef struct packed {
      ball_color_type color;
      dist_type       dist_sq;
   } color_match_type;

   typedef struct packed {
      loc_type         loc;
      reading_vec_type rd;
      logic            typed;
      ball_color_type  color;
      dist_type        dist_sq;
   } stim_row_type;

   // Calibrated centroids: [stand][class][reading], class order red..yellow
   localparam reading_type CENTROIDS [3][6][5] = '{
      '{
         '{10'd1023, 10'd440, 10'd851, 10'd977, 10'd408},
         '{10'd1023, 10'd716, 10'd636, 10'd862, 10'd480},
         '{10'd1023, 10'd731, 10'd602, 10'd933, 10'd481},
         '{10'd1007, 10'd227, 10'd315, 10'd655, 10'd156},
         '{10'd1022, 10'd902, 10'd881, 10'd985, 10'd774},
         '{10'd1019, 10'd227, 10'd368, 10'd899, 10'd175}
      },
      '{
         '{10'd1022, 10'd639, 10'd826, 10'd969, 10'd558},
         '{10'd1022, 10'd913, 10'd653, 10'd868, 10'd579},
         '{10'd1022, 10'd901, 10'd571, 10'd937, 10'd524},
         '{10'd1010, 10'd389, 10'd290, 10'd661, 10'd207},
         '{10'd1022, 10'd967, 10'd863, 10'd976, 10'd801},
         '{10'd1020, 10'd444, 10'd380, 10'd906, 10'd273}
      },
      '{
         '{10'd1023, 10'd654, 10'd965, 10'd932, 10'd597},
         '{10'd1023, 10'd875, 10'd873, 10'd659, 10'd561},
         '{10'd1022, 10'd930, 10'd866, 10'd855, 10'd702},
         '{10'd1022, 10'd404, 10'd580, 10'd404, 10'd240},
         '{10'd1022, 10'd912, 10'd944, 10'd885, 10'd758},
         '{10'd1016, 10'd412, 10'd652, 10'd761, 10'd329}
      }
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   loc_type     req_location_sel = '0;
   reading_type req_reading_off = '0;
   reading_type req_reading_red = '0;
   reading_type req_reading_green = '0;
   reading_type req_reading_blue = '0;
   reading_type req_reading_white = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   class_type   rsp_ball_class;
   dist_type    rsp_best_distance_sq;

   color_match_type pending_colors [$];
   stim_row_type    directed_rows [$];
   color_match_type oldest_color;
   int          mismatches = 0;
   int          cycle_count = 0;
   int          stall_left = 0;
   logic        calm = 1'b0;

   nearest_centroid_color_classifier uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_location_sel     (req_location_sel),
      .req_reading_off      (req_reading_off),
      .req_reading_red      (req_reading_red),
      .req_reading_green    (req_reading_green),
      .req_reading_blue     (req_reading_blue),
      .req_reading_white    (req_reading_white),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_ball_class       (rsp_ball_class),
      .rsp_best_distance_sq (rsp_best_distance_sq)
   );

   always #6 clock = ~clock;

   // Nearest centroid by squared distance; first class wins a tie
   function automatic color_match_type classify_color(loc_type loc, reading_vec_type rd);
      color_match_type best;
      logic [31:0] acc;
      logic [31:0] best_acc;
      int          diff;
      best.color = CLS_NONE;
      best.dist_sq = '0;
      best_acc = '0;
      if (loc < NUM_LOCATIONS) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            acc = '0;
            for (int i = 0; i < NUM_READINGS; i++) begin
               diff = int'(rd[i]) - int'(CENTROIDS[loc][c][i]);
               acc = acc + diff * diff;
            end
            if (c == 0 || acc < best_acc) begin
               best_acc = acc;
               best.color = ball_color_type'(c);
            end
         end
         best.dist_sq = dist_type'(best_acc);
      end
      return best;
   endfunction

   function automatic stim_row_type row(loc_type loc, int off, int red, int green, int blue,
                                        int white, logic typed, ball_color_type color,
                                        int dist_sq);
      stim_row_type r;
      r.loc = loc;
      r.rd[RD_OFF] = reading_type'(off);
      r.rd[RD_RED] = reading_type'(red);
      r.rd[RD_GREEN] = reading_type'(green);
      r.rd[RD_BLUE] = reading_type'(blue);
      r.rd[RD_WHITE] = reading_type'(white);
      r.typed = typed;
      r.color = color;
      r.dist_sq = dist_type'(dist_sq);
      return r;
   endfunction

   function automatic reading_type clamp_reading(int v);
      if (v < 0) return '0;
      if (v > 1023) return '1;
      return reading_type'(v);
   endfunction

   // Drive one item and hold it until accepted; optional idle gap first
   task automatic send_sample(loc_type loc, reading_vec_type rd, color_match_type expected);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_location_sel <= loc;
      req_reading_off <= rd[RD_OFF];
      req_reading_red <= rd[RD_RED];
      req_reading_green <= rd[RD_GREEN];
      req_reading_blue <= rd[RD_BLUE];
      req_reading_white <= rd[RD_WHITE];
      pending_colors.push_back(expected);
      do @(posedge clock); while (req_stall);
   endtask

   // Output stall: random bursts, none while calm
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_colors.size() == 0) begin
            mismatches++;
            $display("%0t unexpected item: class %0d dist %0d", $time,
                     rsp_ball_class, rsp_best_distance_sq);
         end else begin
            oldest_color = pending_colors.pop_front();
            if (rsp_ball_class !== oldest_color.color) begin
               mismatches++;
               $display("%0t ball_class: expected %0d actual %0d", $time,
                        oldest_color.color, rsp_ball_class);
            end
            if (rsp_best_distance_sq !== oldest_color.dist_sq) begin
               mismatches++;
               $display("%0t best_distance_sq: expected %0d actual %0d", $time,
                        oldest_color.dist_sq, rsp_best_distance_sq);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("nearest_centroid_color_classifier_tb: errors");
         $finish;
      end
   end

   // Stimulus
   initial begin
      stim_row_type    r;
      reading_vec_type rd;
      loc_type         loc;
      color_match_type m;
      int          kind;
      int          c1;
      int          c2;
      int          spread;

      // Zeros and full scale at every stand and the unknown location
      for (int s = 0; s < 3; s++) begin
         directed_rows.push_back(row(loc_type'(s), 0, 0, 0, 0, 0, 1'b0, CLS_NONE, 0));
         directed_rows.push_back(row(loc_type'(s), 1023, 1023, 1023, 1023, 1023,
                                     1'b0, CLS_NONE, 0));
      end
      directed_rows.push_back(row(2'd3, 0, 0, 0, 0, 0, 1'b1, CLS_NONE, 0));
      directed_rows.push_back(row(2'd3, 1023, 1023, 1023, 1023, 1023, 1'b1, CLS_NONE, 0));
      directed_rows.push_back(row(2'd3, 1023, 440, 851, 977, 408, 1'b1, CLS_NONE, 0));
      // Exact centroid hits give distance zero
      directed_rows.push_back(row(2'd0, 1023, 440, 851, 977, 408, 1'b1, CLS_RED, 0));
      directed_rows.push_back(row(2'd0, 1019, 227, 368, 899, 175, 1'b1, CLS_YELLOW, 0));
      directed_rows.push_back(row(2'd1, 1022, 913, 653, 868, 579, 1'b1, CLS_BLUE, 0));
      directed_rows.push_back(row(2'd1, 1022, 967, 863, 976, 801, 1'b1, CLS_BLACK, 0));
      directed_rows.push_back(row(2'd2, 1022, 930, 866, 855, 702, 1'b1, CLS_GREEN, 0));
      directed_rows.push_back(row(2'd2, 1022, 404, 580, 404, 240, 1'b1, CLS_WHITE, 0));
      directed_rows.push_back(row(2'd1, 1010, 389, 290, 661, 207, 1'b1, CLS_WHITE, 0));
      // Equidistant from red and blue at stand 0: red must win
      directed_rows.push_back(row(2'd0, 1023, 575, 744, 917, 453, 1'b0, CLS_NONE, 0));
      // Alternating bit patterns
      directed_rows.push_back(row(2'd0, 'h2AA, 'h155, 'h2AA, 'h155, 'h2AA, 1'b0, CLS_NONE, 0));
      directed_rows.push_back(row(2'd1, 'h155, 'h2AA, 'h155, 'h2AA, 'h155, 1'b0, CLS_NONE, 0));
      directed_rows.push_back(row(2'd2, 'h155, 'h2AA, 'h2AA, 'h155, 'h155, 1'b0, CLS_NONE, 0));
      directed_rows.push_back(row(2'd3, 'h155, 'h2AA, 'h155, 'h2AA, 'h155, 1'b1, CLS_NONE, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k]) begin
         r = directed_rows[k];
         if (r.typed) begin
            m.color = r.color;
            m.dist_sq = r.dist_sq;
         end else begin
            m = classify_color(r.loc, r.rd);
         end
         send_sample(r.loc, r.rd, m);
      end

      // Hold off until the pipeline has delivered everything
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 200 && n < 260) || (n >= RANDOM_ITEMS - 60);
         kind = $urandom_range(0, 99);
         loc = loc_type'($urandom_range(0, 2));
         if (kind < 40) begin
            // Near one centroid
            c1 = $urandom_range(0, NUM_CLASSES - 1);
            case ($urandom_range(0, 2))
               0: spread = 8;
               1: spread = 40;
               default: spread = 150;
            endcase
            for (int i = 0; i < NUM_READINGS; i++)
               rd[i] = clamp_reading(int'(CENTROIDS[loc][c1][i]) + $urandom_range(0, 2 * spread)
                                     - spread);
         end else if (kind < 60) begin
            // Between two centroids, where ties and close calls live
            c1 = $urandom_range(0, NUM_CLASSES - 1);
            c2 = $urandom_range(0, NUM_CLASSES - 1);
            for (int i = 0; i < NUM_READINGS; i++)
               rd[i] = clamp_reading((int'(CENTROIDS[loc][c1][i]) + int'(CENTROIDS[loc][c2][i]))
                                     / 2 + $urandom_range(0, 6) - 3);
         end else if (kind < 85) begin
            for (int i = 0; i < NUM_READINGS; i++)
               rd[i] = reading_type'($urandom);
         end else if (kind < 92) begin
            loc = loc_type'($urandom_range(0, 3));
            for (int i = 0; i < NUM_READINGS; i++)
               rd[i] = $urandom_range(0, 1) ? '1 : '0;
         end else begin
            loc = 2'd3;
            for (int i = 0; i < NUM_READINGS; i++)
               rd[i] = reading_type'($urandom);
         end
         send_sample(loc, rd, classify_color(loc, rd));
      end

      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("nearest_centroid_color_classifier_tb: clean");
      end else begin
         $display("nearest_centroid_color_classifier_tb: errors");
      end
      $finish;
   end

endmodule
